@@ design/tnc_pkg.sv @@
// ----------------------------------------------------------------------------
// tnc_pkg
// shared constants, tag kind codes and stack control types
// ----------------------------------------------------------------------------
`default_nettype none

package tnc_pkg;

  localparam int unsigned STACK_DEPTH   = 64;
  localparam int unsigned NAME_BITS     = 16;
  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned INDEX_BITS    = 16;
  localparam int unsigned KIND_BITS     = 2;

  localparam int unsigned STACK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned FILL_W   = $clog2(STACK_DEPTH + 1);

  typedef enum logic [KIND_BITS-1:0] {
    KIND_OPEN    = 2'd0,
    KIND_CLOSE   = 2'd1,
    KIND_SELF    = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;

  // commands from the sequencing logic to the stack
  typedef struct packed {
    logic                 push;
    logic                 pop;
    logic                 clear;
    logic [NAME_BITS-1:0] code;
  } stack_cmd_t;

  // stack status as seen by the sequencing logic
  typedef struct packed {
    logic [FILL_W-1:0]    fill;
    logic [NAME_BITS-1:0] top;
    logic                 empty;
    logic                 full;
    logic                 one_left;
  } stack_stat_t;

endpackage

`default_nettype wire

@@ design/tnc_ifs.sv @@
// ----------------------------------------------------------------------------
// tnc interfaces
// valid/ready channels for tag items and verdict items
// ----------------------------------------------------------------------------
`default_nettype none

interface tnc_tag_if;
  logic                               valid;
  logic                               ready;
  logic [tnc_pkg::KIND_BITS-1:0]      tag_kind;
  logic [tnc_pkg::NAME_BITS-1:0]      name_code;
  logic                               last_tag;

  modport source (output valid, output tag_kind, output name_code, output last_tag,
                  input ready);
  modport sink   (input valid, input tag_kind, input name_code, input last_tag,
                  output ready);
endinterface

interface tnc_verdict_if;
  logic                               valid;
  logic                               ready;
  logic                               nesting_ok;
  logic [tnc_pkg::INDEX_BITS-1:0]     last_open_index;

  modport source (output valid, output nesting_ok, output last_open_index,
                  input ready);
  modport sink   (input valid, input nesting_ok, input last_open_index,
                  output ready);
endinterface

`default_nettype wire

@@ design/tag_nesting_checker.sv @@
// ----------------------------------------------------------------------------
// tag_nesting_checker
// checks that a stream of open/close tags nests properly, one verdict per sequence
// ----------------------------------------------------------------------------
//
//   port       dir   handshake     carries
//   tag_i      in    valid/ready   tag_kind, name_code, last_tag
//   verdict_o  out   valid/ready   nesting_ok, last_open_index
//
// one tag per cycle while the verdict slot is free or being emptied: the stack
// top is cached in a register and the entry below it is prefetched from the
// stack memory every cycle, so a push or pop never waits on the memory's read
// a verdict appears in the cycle after the transfer of the tag marked last
// reset clears fill, position, failure state and the output valid flag; the
// stack memory itself is never cleared, only entries below the fill are used
// a waiting verdict holds tag_i only until verdict_o.ready is seen; the output
// register takes the next verdict in the cycle the old one is transferred
// ----------------------------------------------------------------------------
`default_nettype none

module tag_nesting_checker (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  tnc_tag_if.sink       tag_i,
  tnc_verdict_if.source verdict_o
);
  import tnc_pkg::*;

  // sequence state
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] open_pos_q, open_pos_d;
  logic                     failed_q, failed_d;

  // output register
  logic                     out_valid_q, out_valid_d;
  logic                     out_ok_q, out_ok_d;
  logic [INDEX_BITS-1:0]    out_index_q, out_index_d;

  stack_cmd_t  cmd;
  stack_stat_t stat;

  logic accept;
  logic examine;
  logic is_open, is_close;
  logic name_match;
  logic fail_full, fail_close;
  logic failed_now;
  logic empty_after;

  // a new tag may enter whenever the verdict slot is free or being emptied
  assign tag_i.ready = !out_valid_q || verdict_o.ready;
  assign accept      = tag_i.valid && tag_i.ready;

  // once failed, later tags only advance the position
  assign examine    = accept && !failed_q;
  assign is_open    = (tag_i.tag_kind == KIND_OPEN);
  assign is_close   = (tag_i.tag_kind == KIND_CLOSE);
  assign name_match = (stat.top == tag_i.name_code);

  assign fail_full  = examine && is_open && stat.full;
  assign fail_close = examine && is_close && (stat.empty || !name_match);
  assign failed_now = failed_q || fail_full || fail_close;

  assign cmd.push  = examine && is_open && !stat.full;
  assign cmd.pop   = examine && is_close && !stat.empty && name_match;
  assign cmd.clear = accept && tag_i.last_tag;
  assign cmd.code  = tag_i.name_code;

  // stack empty once this tag is applied
  assign empty_after = (stat.empty && !cmd.push) || (stat.one_left && cmd.pop);

  tnc_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  always_comb begin
    pos_d       = pos_q;
    open_pos_d  = open_pos_q;
    failed_d    = failed_q;
    out_valid_d = out_valid_q && !verdict_o.ready;
    out_ok_d    = out_ok_q;
    out_index_d = out_index_q;

    if (accept) begin
      if (cmd.push) begin
        open_pos_d = pos_q;
      end
      failed_d = failed_now;
      pos_d    = POSITION_BITS'(pos_q + POSITION_BITS'(1));

      // verdict on the last tag, then back to the reset state
      if (tag_i.last_tag) begin
        out_valid_d = 1'b1;
        out_ok_d    = !failed_now && empty_after;
        out_index_d = INDEX_BITS'(open_pos_d);
        pos_d       = '0;
        open_pos_d  = '0;
        failed_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      open_pos_q  <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      open_pos_q  <= open_pos_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // verdict payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_ok_q    <= out_ok_d;
    out_index_q <= out_index_d;
  end

  assign verdict_o.valid           = out_valid_q;
  assign verdict_o.nesting_ok      = out_ok_q;
  assign verdict_o.last_open_index = out_index_q;

endmodule

`default_nettype wire

@@ design/tnc_stack.sv @@
// ----------------------------------------------------------------------------
// tnc_stack
// name stack in a synchronous memory with cached top and prefetched second entry
// ----------------------------------------------------------------------------
`default_nettype none

module tnc_stack (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tnc_pkg::stack_cmd_t  cmd_i,
  output tnc_pkg::stack_stat_t      stat_o
);
  import tnc_pkg::*;

  logic [NAME_BITS-1:0] mem [STACK_DEPTH];

  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [NAME_BITS-1:0] top_q, top_d;
  logic [NAME_BITS-1:0] second_q;   // entry at fill_q - 2
  logic [STACK_AW-1:0]  rd_addr;
  logic [FILL_W-1:0]    rd_fill;

  always_comb begin
    fill_d = fill_q;
    top_d  = top_q;
    if (cmd_i.clear) begin
      fill_d = '0;
    end else if (cmd_i.push) begin
      fill_d = FILL_W'(fill_q + FILL_W'(1));
      top_d  = cmd_i.code;
    end else if (cmd_i.pop) begin
      fill_d = FILL_W'(fill_q - FILL_W'(1));
      top_d  = second_q;
    end
  end

  // prefetch the entry below the next top; never the address written now
  assign rd_fill = FILL_W'(fill_d - FILL_W'(2));
  assign rd_addr = rd_fill[STACK_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[fill_q[STACK_AW-1:0]] <= cmd_i.code;
    end
    second_q <= mem[rd_addr];
    top_q    <= top_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign stat_o.fill     = fill_q;
  assign stat_o.top      = top_q;
  assign stat_o.empty    = (fill_q == '0);
  assign stat_o.full     = (fill_q >= FILL_W'(STACK_DEPTH));
  assign stat_o.one_left = (fill_q == FILL_W'(1));

endmodule

`default_nettype wire

@@ design/tnc_checker.sv @@
// ----------------------------------------------------------------------------
// tnc_checker
// port-level checks on tag and verdict transfers
// ----------------------------------------------------------------------------
`default_nettype none

module tnc_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_i,
  input wire logic                           in_last_i,
  input wire logic                           out_valid_i,
  input wire logic                           out_ready_i,
  input wire logic                           out_ok_i,
  input wire logic [tnc_pkg::INDEX_BITS-1:0] out_index_i
);

  logic in_xfer;
  logic out_free;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_free = !out_valid_i || out_ready_i;

  // stalled verdict holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_ok_i) && $stable(out_index_i))
    else $error("verdict changed while stalled");

  // last tag yields a verdict next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_last_i |=> out_valid_i)
    else $error("no verdict after last tag");

  // no verdict invented for an inner tag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_xfer || !in_last_i) && out_free |=> !out_valid_i)
    else $error("verdict without last tag");

  // an empty verdict slot never blocks tags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("tags blocked with no verdict pending");

endmodule

bind tag_nesting_checker tnc_checker u_tnc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (tag_i.valid),
  .in_ready_i  (tag_i.ready),
  .in_last_i   (tag_i.last_tag),
  .out_valid_i (verdict_o.valid),
  .out_ready_i (verdict_o.ready),
  .out_ok_i    (verdict_o.nesting_ok),
  .out_index_i (verdict_o.last_open_index)
);

`default_nettype wire

@@ tb/tb_tag_nesting_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tag_nesting_checker
// self-checking bench: random tag streams against a scoreboard of verdicts
// ----------------------------------------------------------------------------
// tags are queued by the stimulus process and offered by a clocked driver; on
// each tag transfer the bench's own nesting tracker works out the verdict that
// the tag causes, and a clocked monitor compares each verdict transfer with
// the oldest one waiting; three phases change how often each side idles
// ----------------------------------------------------------------------------

module tb_tag_nesting_checker;

  import tnc_pkg::*;

  localparam int TIMEOUT_CYCLES = 2000;  // cycles with no transfer at all
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES   = 10;    // settle time after the last verdict
  localparam int PHASE_ITEMS    = 400;   // random tags per phase
  localparam int LONG_SEQ_LEN   = 200;   // tags in one long run of matched pairs

  typedef struct packed {
    kind_e                kind;
    logic [NAME_BITS-1:0] code;
    logic                 last;
  } tag_t;

  typedef struct packed {
    logic                  ok;
    logic [INDEX_BITS-1:0] index;
  } verdict_t;

  // shapes of random tag sequences
  typedef enum int {
    SEQ_NESTED,
    SEQ_BROKEN,
    SEQ_NOISE,
    SEQ_FULL
  } seq_mode_e;

  logic clk;
  logic rst_n;

  tnc_tag_if     tag_bus ();
  tnc_verdict_if verdict_bus ();

  tag_nesting_checker u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .tag_i     (tag_bus),
    .verdict_o (verdict_bus)
  );

  // tags waiting to be offered; the head sits on the bus while valid is high
  tag_t     pending_tags[$];
  // verdicts owed by the block, oldest first
  verdict_t verdict_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        pressure_req;
  logic        pressure_seen;
  int          hold_left;
  int          idle_cycles;
  int          error_count;
  int          queued_items;

  // nesting tracker state, mirrors what the block must hold
  logic [NAME_BITS-1:0]     nest_stack[STACK_DEPTH];
  int                       nest_fill;
  logic [POSITION_BITS-1:0] tag_pos;
  logic [POSITION_BITS-1:0] open_pos;
  logic                     nest_failed;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // advance the nesting tracker by one tag, owe a verdict on the last one
  function automatic void nesting_step(input tag_t t);
    verdict_t v;
    if (!nest_failed) begin
      case (t.kind)
        KIND_OPEN: begin
          if (nest_fill >= STACK_DEPTH) begin
            // full stack: not pushed, open position kept
            nest_failed = 1'b1;
          end else begin
            nest_stack[nest_fill] = t.code;
            nest_fill++;
            open_pos = tag_pos;
          end
        end
        KIND_CLOSE: begin
          // close on empty stack or name mismatch; stack left untouched
          if (nest_fill == 0 || nest_stack[nest_fill-1] != t.code) begin
            nest_failed = 1'b1;
          end else begin
            nest_fill--;
          end
        end
        default: ;  // self-closing and unknown tags only move the position
      endcase
    end
    tag_pos = tag_pos + 1'b1;  // wraps at the position width
    if (t.last) begin
      v.ok    = !nest_failed && (nest_fill == 0);
      v.index = INDEX_BITS'(open_pos);
      verdict_q.insert(verdict_q.size(), v);
      nest_fill   = 0;
      tag_pos     = '0;
      open_pos    = '0;
      nest_failed = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers the head of the pending queue, holds it until transferred
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : tag_driver
    logic took;
    took = tag_bus.valid && tag_bus.ready;
    if (!rst_n) begin
      tag_bus.valid <= 1'b0;
    end else begin
      if (took) begin
        nesting_step(pending_tags[0]);
        void'(pending_tags.pop_front());
      end
      // a tag still waiting for ready stays on the bus unchanged
      if (!tag_bus.valid || took) begin
        if (pending_tags.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          tag_bus.valid     <= 1'b1;
          tag_bus.tag_kind  <= pending_tags[0].kind;
          tag_bus.name_code <= pending_tags[0].code;
          tag_bus.last_tag  <= pending_tags[0].last;
        end else begin
          tag_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each verdict transfer and drives ready, with one long
  // hold-off counted here once the stimulus asks for it
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : verdict_monitor
    verdict_t exp_v;
    if (!rst_n) begin
      verdict_bus.ready <= 1'b0;
      hold_left         <= 0;
      pressure_seen     <= 1'b0;
    end else begin
      if (verdict_bus.valid && verdict_bus.ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: verdict with none owed: ok=%0b index=%0d", $time,
                   verdict_bus.nesting_ok, verdict_bus.last_open_index);
          error_count++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (verdict_bus.nesting_ok !== exp_v.ok) begin
            $display("%0t: nesting_ok mismatch: expected %0b, actual %0b", $time,
                     exp_v.ok, verdict_bus.nesting_ok);
            error_count++;
          end
          if (verdict_bus.last_open_index !== exp_v.index) begin
            $display("%0t: last_open_index mismatch: expected %0d, actual %0d", $time,
                     exp_v.index, verdict_bus.last_open_index);
            error_count++;
          end
        end
      end
      if (pressure_req && !pressure_seen) begin
        pressure_seen     <= 1'b1;
        hold_left         <= HOLD_CYCLES;
        verdict_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left         <= hold_left - 1;
        verdict_bus.ready <= 1'b0;
      end else begin
        verdict_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: too long with no transfer on either channel
  always @(posedge clk) begin : watchdog
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((tag_bus.valid && tag_bus.ready) ||
                 (verdict_bus.valid && verdict_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= TIMEOUT_CYCLES) begin
      $display("%0t: timeout, %0d tags pending, %0d verdicts owed", $time,
               pending_tags.size(), verdict_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one time in four one of four shared names, so that random closes sometimes match
  function automatic logic [NAME_BITS-1:0] pick_code();
    if ($urandom_range(3) == 0) return NAME_BITS'($urandom_range(3));
    return NAME_BITS'($urandom());
  endfunction

  task automatic add_tag(input kind_e k, input logic [NAME_BITS-1:0] c,
                         input logic l);
    tag_t t;
    t.kind = k;
    t.code = c;
    t.last = l;
    pending_tags.insert(pending_tags.size(), t);
    queued_items++;
  endtask

  // queue a sequence, only its final tag marked last
  task automatic push_sequence(input tag_t seq[$]);
    foreach (seq[i]) add_tag(seq[i].kind, seq[i].code, i == seq.size() - 1);
  endtask

  task automatic make_sequence(input seq_mode_e mode, output tag_t seq[$]);
    logic [NAME_BITS-1:0] open_codes[$];
    tag_t                 t;
    int                   len;
    int                   max_depth;
    int                   r;
    int                   idx;
    seq = {};
    t.last = 1'b0;
    case (mode)
      SEQ_FULL: begin
        // fill the stack to the brim, sometimes past it
        len = $urandom_range(STACK_DEPTH, STACK_DEPTH + 2);
        for (int i = 0; i < len; i++) begin
          t.kind = KIND_OPEN;
          t.code = pick_code();
          open_codes.insert(open_codes.size(), t.code);
          seq.insert(seq.size(), t);
        end
        while (open_codes.size() > 0) begin
          t.kind = KIND_CLOSE;
          t.code = open_codes.pop_back();
          seq.insert(seq.size(), t);
        end
      end
      SEQ_NOISE: begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          t.kind = kind_e'($urandom_range(3));
          t.code = pick_code();
          seq.insert(seq.size(), t);
        end
      end
      default: begin
        // well-formed nesting with skipped tags mixed in, then one change for SEQ_BROKEN
        len       = $urandom_range(1, 20);
        max_depth = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(99);
          if (open_codes.size() > 0 && (r < 40 || open_codes.size() >= max_depth)) begin
            t.kind = KIND_CLOSE;
            t.code = open_codes.pop_back();
          end else if (r < 80) begin
            t.kind = KIND_OPEN;
            t.code = pick_code();
            open_codes.insert(open_codes.size(), t.code);
          end else begin
            t.kind = kind_e'($urandom_range(KIND_SELF, KIND_UNKNOWN));
            t.code = pick_code();
          end
          seq.insert(seq.size(), t);
        end
        while (open_codes.size() > 0) begin
          t.kind = KIND_CLOSE;
          t.code = open_codes.pop_back();
          seq.insert(seq.size(), t);
        end
        if (mode == SEQ_BROKEN) begin
          idx = $urandom_range(seq.size() - 1);
          case ($urandom_range(3))
            0: seq[idx].code[$urandom_range(NAME_BITS - 1)] ^= 1'b1;
            1: seq[idx].kind = kind_e'($urandom_range(3));
            2: seq.delete(idx);
            default: begin
              t.kind = KIND_CLOSE;
              t.code = pick_code();
              seq.insert(idx, t);
            end
          endcase
          if (seq.size() == 0) begin
            t.kind = KIND_SELF;
            t.code = pick_code();
            seq.insert(seq.size(), t);
          end
        end
      end
    endcase
  endtask

  task automatic random_sequences(input int count);
    tag_t      seq[$];
    seq_mode_e mode;
    int        r;
    int        start;
    start = queued_items;
    while (queued_items - start < count) begin
      r = $urandom_range(99);
      if (r < 60)      mode = SEQ_NESTED;
      else if (r < 84) mode = SEQ_BROKEN;
      else if (r < 97) mode = SEQ_NOISE;
      else             mode = SEQ_FULL;
      make_sequence(mode, seq);
      push_sequence(seq);
    end
  endtask

  // all tags transferred and every owed verdict seen
  task automatic wait_drained();
    while (pending_tags.size() != 0 || verdict_q.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus: control changes happen at the falling edge, away from the
  // clocked driver and monitor
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    tag_t seq[$];
    logic [NAME_BITS-1:0] c;

    tag_bus.valid     = 1'b0;
    tag_bus.tag_kind  = KIND_SELF;
    tag_bus.name_code = '0;
    tag_bus.last_tag  = 1'b0;
    verdict_bus.ready = 1'b0;
    rst_n         = 1'b0;
    send_idle_pct = 32;
    recv_idle_pct = 83;
    pressure_req  = 1'b0;
    error_count   = 0;
    queued_items  = 0;
    nest_fill     = 0;
    tag_pos       = '0;
    open_pos      = '0;
    nest_failed   = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // matched nesting with extreme names and a skipped tag, verdict on unknown
    add_tag(KIND_OPEN,    16'hFFFF, 1'b0);
    add_tag(KIND_SELF,    16'h0000, 1'b0);
    add_tag(KIND_OPEN,    16'h0000, 1'b0);
    add_tag(KIND_CLOSE,   16'h0000, 1'b0);
    add_tag(KIND_CLOSE,   16'hFFFF, 1'b0);
    add_tag(KIND_UNKNOWN, 16'hFFFF, 1'b1);
    // close with nothing open
    add_tag(KIND_CLOSE,   16'h1234, 1'b1);
    // name mismatch, later tags not examined
    add_tag(KIND_OPEN,    16'hAAAA, 1'b0);
    add_tag(KIND_CLOSE,   16'h5555, 1'b0);
    add_tag(KIND_OPEN,    16'h1111, 1'b0);
    add_tag(KIND_CLOSE,   16'h1111, 1'b1);
    // open left unclosed
    add_tag(KIND_OPEN,    16'h0001, 1'b1);
    // lone skipped tag
    add_tag(KIND_SELF,    16'h5A5A, 1'b1);
    // extra close after a matched pair
    add_tag(KIND_OPEN,    16'h00FF, 1'b0);
    add_tag(KIND_CLOSE,   16'h00FF, 1'b0);
    add_tag(KIND_CLOSE,   16'h00FF, 1'b1);
    // open as the last tag after a matched pair
    add_tag(KIND_OPEN,    16'h8000, 1'b0);
    add_tag(KIND_CLOSE,   16'h8000, 1'b0);
    add_tag(KIND_OPEN,    16'h7FFF, 1'b1);

    // phase one: sender idles a little, receiver a lot
    random_sequences(PHASE_ITEMS);
    wait_drained();

    // phase two: the other way round
    send_idle_pct = 83;
    recv_idle_pct = 32;
    random_sequences(PHASE_ITEMS);
    wait_drained();

    // phase three: no idling; first a long receiver hold-off while short
    // sequences keep coming, so the block backs up onto its input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pressure_req  = 1'b1;
    for (int i = 0; i < 40; i++) begin
      make_sequence(SEQ_NOISE, seq);
      push_sequence(seq);
    end
    random_sequences(PHASE_ITEMS);

    // one long sequence of matched pairs between skipped tags; the last open
    // sits a couple of tags before the end
    for (int i = 0; i < LONG_SEQ_LEN; i++) begin
      case (i % 4)
        1: begin
          c = pick_code();
          add_tag(KIND_OPEN, c, 1'b0);
        end
        2: add_tag(KIND_CLOSE, c, 1'b0);
        default: add_tag(kind_e'($urandom_range(KIND_SELF, KIND_UNKNOWN)), pick_code(),
                         i == LONG_SEQ_LEN - 1);
      endcase
    end
    wait_drained();

    // let any stray verdict show up before the final word
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/tnc_pkg.sv
design/tnc_ifs.sv
design/tnc_stack.sv
design/tag_nesting_checker.sv
design/tnc_checker.sv
tb/tb_tag_nesting_checker.sv
